[sv/pbt_pkg.sv]
package pbt_pkg;

  localparam int FIELD_W     = 32;
  localparam int COORD_WIDTH = 32;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int CROSS_W     = PROD_W + 1;

  localparam int IN_TDATA_W  = 2 * FIELD_W;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 8;
  localparam int CFG_INDEX_W = 2;

  localparam int USER_START  = 0;
  localparam int USER_END    = 1;
  localparam int USER_CLOSED = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t max_x;
    coord_t max_y;
  } box_t;

  typedef struct packed {
    logic oend;
    logic seg_a;
    logic seg_b;
  } tag_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BOX_MIN_X = 2'd0,
    REG_BOX_MIN_Y = 2'd1,
    REG_BOX_MAX_X = 2'd2,
    REG_BOX_MAX_Y = 2'd3
  } cfg_reg_e;

  function automatic coord_t coord_of(input logic [FIELD_W-1:0] v);
    return coord_t'($signed(v));
  endfunction

endpackage

[sv/pbt_seg.sv]
module pbt_seg (
  input  logic           clk,
  input  logic           en2,
  input  logic           en3,
  input  pbt_pkg::box_t   box,
  input  pbt_pkg::point_t a,
  input  pbt_pkg::point_t b,
  output logic           hit
);
  import pbt_pkg::*;

  // stage 2: differences and sign-only tests
  diff_t ux, uy, dxn, dxx, dyn, dyx;
  logic  in_hit2, bb2;
  logic [3:0] e34_2;

  // stage 3: products
  prod_t p_ux_dyn, p_ux_dyx, p_uy_dxn, p_uy_dxx;
  logic  in_hit3, bb3;
  logic [3:0] e34_3;

  logic in_a, in_b, bb;
  logic [3:0] e34;
  logic d3_b, d4_b, d3_r, d4_r, d3_t, d4_t, d3_l, d4_l;
  cross_t c00, c10, c11, c01;
  logic q00, q10, q11, q01;
  logic [3:0] crossed;

  always_comb begin
    in_a = (box.min_x <= a.x) && (a.x <= box.max_x) &&
           (box.min_y <= a.y) && (a.y <= box.max_y);
    in_b = (box.min_x <= b.x) && (b.x <= box.max_x) &&
           (box.min_y <= b.y) && (b.y <= box.max_y);
    bb = ((a.x <= box.max_x) || (b.x <= box.max_x)) &&
         ((box.min_x <= a.x) || (box.min_x <= b.x)) &&
         ((a.y <= box.max_y) || (b.y <= box.max_y)) &&
         ((box.min_y <= a.y) || (box.min_y <= b.y));
    // box edge direction is axis aligned, so its cross products reduce to sign tests
    d3_b = ((box.max_x > box.min_x) && (a.y > box.min_y)) ||
           ((box.max_x < box.min_x) && (a.y < box.min_y));
    d4_b = ((box.max_x > box.min_x) && (b.y > box.min_y)) ||
           ((box.max_x < box.min_x) && (b.y < box.min_y));
    d3_r = ((box.max_y > box.min_y) && (a.x < box.max_x)) ||
           ((box.max_y < box.min_y) && (a.x > box.max_x));
    d4_r = ((box.max_y > box.min_y) && (b.x < box.max_x)) ||
           ((box.max_y < box.min_y) && (b.x > box.max_x));
    d3_t = ((box.min_x > box.max_x) && (a.y > box.max_y)) ||
           ((box.min_x < box.max_x) && (a.y < box.max_y));
    d4_t = ((box.min_x > box.max_x) && (b.y > box.max_y)) ||
           ((box.min_x < box.max_x) && (b.y < box.max_y));
    d3_l = ((box.min_y > box.max_y) && (a.x < box.min_x)) ||
           ((box.min_y < box.max_y) && (a.x > box.min_x));
    d4_l = ((box.min_y > box.max_y) && (b.x < box.min_x)) ||
           ((box.min_y < box.max_y) && (b.x > box.min_x));
    e34 = {d3_l != d4_l, d3_t != d4_t, d3_r != d4_r, d3_b != d4_b};
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      ux      <= diff_t'(b.x) - diff_t'(a.x);
      uy      <= diff_t'(b.y) - diff_t'(a.y);
      dxn     <= diff_t'(box.min_x) - diff_t'(a.x);
      dxx     <= diff_t'(box.max_x) - diff_t'(a.x);
      dyn     <= diff_t'(box.min_y) - diff_t'(a.y);
      dyx     <= diff_t'(box.max_y) - diff_t'(a.y);
      in_hit2 <= in_a || in_b;
      bb2     <= bb;
      e34_2   <= e34;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      p_ux_dyn <= prod_t'(ux) * prod_t'(dyn);
      p_ux_dyx <= prod_t'(ux) * prod_t'(dyx);
      p_uy_dxn <= prod_t'(uy) * prod_t'(dxn);
      p_uy_dxx <= prod_t'(uy) * prod_t'(dxx);
      in_hit3  <= in_hit2;
      bb3      <= bb2;
      e34_3    <= e34_2;
    end
  end

  // cross(u, corner - a) for the four box corners
  always_comb begin
    c00 = cross_t'(p_ux_dyn) - cross_t'(p_uy_dxn);
    c10 = cross_t'(p_ux_dyn) - cross_t'(p_uy_dxx);
    c11 = cross_t'(p_ux_dyx) - cross_t'(p_uy_dxx);
    c01 = cross_t'(p_ux_dyx) - cross_t'(p_uy_dxn);
    q00 = !c00[CROSS_W-1] && (c00 != '0);
    q10 = !c10[CROSS_W-1] && (c10 != '0);
    q11 = !c11[CROSS_W-1] && (c11 != '0);
    q01 = !c01[CROSS_W-1] && (c01 != '0);
    crossed = {q01 != q00, q11 != q01, q10 != q11, q00 != q10} & e34_3;
    hit = in_hit3 || (bb3 && (|crossed));
  end

endmodule

[sv/polyline_box_touch_test.sv]
// Channel   Dir  Handshake              Payload
// s_axis    in   s_axis_tvalid/tready   tdata: point_x, point_y; tuser: start, end, closed;
//                                       tlast: object_end
// m_axis    out  m_axis_tvalid/tready   tdata: touched
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One point per cycle while nothing stalls. A result is on m_axis once the transaction
// carrying object_end has passed the input register, difference stage, product stage
// and output register. Only an unaccepted result stalls the pipeline, and only when
// another result reaches the last stage. rst clears stroke state and all valids.
module polyline_box_touch_test (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [pbt_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // point_x, point_y
  input  logic [pbt_pkg::IN_TUSER_W-1:0]       s_axis_tuser,  // stroke_start, stroke_end,
                                                              // stroke_closed
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [pbt_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,  // touched, zero fill
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pbt_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [pbt_pkg::FIELD_W-1:0]          cfg_data
);
  import pbt_pkg::*;

  box_t   box;
  point_t prev_pt, first_pt;
  logic   point_seen, touch_accum;

  logic   v1, v2, v3;
  tag_t   tag1, tag2, tag3;
  point_t pa1, pc1, pf1;

  logic   en1, en2, en3, go3;
  logic   s_fire;
  point_t cur;
  logic   start, send, closed, oend, ps_eff, stroke_done;
  logic   hit_a, hit_b, hit3;
  logic   out_valid, out_touched;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      box <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_e'(cfg_index))
        REG_BOX_MIN_X: box.min_x <= coord_of(cfg_data);
        REG_BOX_MIN_Y: box.min_y <= coord_of(cfg_data);
        REG_BOX_MAX_X: box.max_x <= coord_of(cfg_data);
        REG_BOX_MAX_Y: box.max_y <= coord_of(cfg_data);
        default: ;
      endcase
    end
  end

  always_comb begin
    go3           = v3 && (!tag3.oend || !out_valid || m_axis_tready);
    en3           = !v3 || go3;
    en2           = !v2 || en3;
    en1           = !v1 || en2;
    s_axis_tready = en1;
    s_fire        = s_axis_tvalid && en1;

    cur.x       = coord_of(s_axis_tdata[FIELD_W-1:0]);
    cur.y       = coord_of(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
    start       = s_axis_tuser[USER_START];
    send        = s_axis_tuser[USER_END];
    closed      = s_axis_tuser[USER_CLOSED];
    oend        = s_axis_tlast;
    ps_eff      = point_seen && !start;
    stroke_done = send || oend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pt    <= '0;
      first_pt   <= '0;
      point_seen <= 1'b0;
    end else if (s_fire) begin
      prev_pt    <= cur;
      if (!ps_eff) begin
        first_pt <= cur;
      end
      point_seen <= !stroke_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= s_fire;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      tag1.oend  <= oend;
      tag1.seg_a <= ps_eff;
      tag1.seg_b <= stroke_done && closed && ps_eff;
      pa1        <= prev_pt;
      pc1        <= cur;
      pf1        <= first_pt;
    end
    if (en2) begin
      tag2 <= tag1;
    end
    if (en3) begin
      tag3 <= tag2;
    end
  end

  // segment from the previous point to this one
  pbt_seg u_seg_a (
    .clk (clk),
    .en2 (en2),
    .en3 (en3),
    .box (box),
    .a   (pa1),
    .b   (pc1),
    .hit (hit_a)
  );

  // closing segment back to the first point of the stroke
  pbt_seg u_seg_b (
    .clk (clk),
    .en2 (en2),
    .en3 (en3),
    .box (box),
    .a   (pc1),
    .b   (pf1),
    .hit (hit_b)
  );

  assign hit3 = touch_accum || (tag3.seg_a && hit_a) || (tag3.seg_b && hit_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_accum <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (go3) begin
        touch_accum <= tag3.oend ? 1'b0 : hit3;
      end
      if (go3 && tag3.oend) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go3 && tag3.oend) begin
      out_touched <= hit3;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-1){1'b0}}, out_touched};

endmodule
